### hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 7;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOCATE = 2'd2;
   localparam logic [1:0] OP_DUMP   = 2'd3;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_BAD_POS   = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]               operation;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] data_out;
      logic [POS_W-1:0]         found_index;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROTATE
   } cell_cmd_type;

   // pos_idx: 0-based insert/delete slot, or the wrap slot (count-1) on rotate
   typedef struct packed {
      cell_cmd_type             cmd;
      logic [POS_W-1:0]         pos_idx;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

### hdl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry and takes a neighbour's on shift or rotate.
// ----------------------------------------------------------------------------
module ple_cell (
   input  logic                              clock,
   input  logic [ple_pkg::POS_W-1:0]         idx,
   input  ple_pkg::cell_ctl_type             ctl,
   input  logic signed [ple_pkg::DATA_W-1:0] left_data,
   input  logic signed [ple_pkg::DATA_W-1:0] right_data,
   input  logic signed [ple_pkg::DATA_W-1:0] head_data,
   output logic signed [ple_pkg::DATA_W-1:0] data,
   output logic signed [ple_pkg::DATA_W-1:0] sel_data
);
   import ple_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (idx == ctl.pos_idx) begin
               entry_in = ctl.value;
            end else if (idx > ctl.pos_idx) begin
               entry_in = left_data;
            end
         end
         CMD_DELETE: begin
            if (idx >= ctl.pos_idx) begin
               entry_in = right_data;
            end
         end
         CMD_ROTATE: begin
            // wrap the head round to the tail of the occupied part
            if (idx == ctl.pos_idx) begin
               entry_in = head_data;
            end else if (idx < ctl.pos_idx) begin
               entry_in = right_data;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data     = entry_ff;
   assign sel_data = (idx == ctl.pos_idx) ? entry_ff : '0;

endmodule

### hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (operation, position, value); rsp_* returns
//   results. Both use valid/stall: a transfer happens when valid is high and
//   stall is low.
//   Insert and delete shift the cells at and beyond the addressed slot
//   together; their one result appears in the output register the cycle
//   after the request is taken, so they sustain one request per cycle while
//   the receiver keeps up. Locate and dump rotate the occupied cells one slot
//   a cycle, count slots in all, reading the head cell; the row ends back in
//   its original order. Locate gives one result at the end of the scan; dump
//   gives one result per cycle, last set on the final entry. An empty dump
//   gives no result; an empty locate gives not found without a scan.
//   The rotation only advances while the output register can be loaded, so
//   rsp_stall holds the scan; req_stall stays high while a scan runs or the
//   output register is full and stalled.
//   Reset empties the list and drops any pending result; cell contents are
//   not cleared and are never read beyond the count.
// ----------------------------------------------------------------------------
module positional_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_data
);
   import ple_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type                state_ff,     state_in;
   logic [CNT_W-1:0]         count_ff,     count_in;
   logic [IDX_W-1:0]         step_ff,      step_in;
   logic                     found_ff,     found_in;
   logic [POS_W-1:0]         hit_idx_ff,   hit_idx_in;
   logic [1:0]               op_ff,        op_in;
   logic signed [DATA_W-1:0] val_ff,       val_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff,       rsp_in;

   cell_ctl_type             ctl;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic signed [DATA_W-1:0] cell_sel  [CAPACITY];
   logic signed [DATA_W-1:0] sel_or;

   logic                     slot_free;
   logic                     accept;
   logic [POS_W:0]           pos_w;
   logic [POS_W:0]           cnt_w;
   logic                     last_step;
   logic                     head_hit;

   // --- cell row -----------------------------------------------------------
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [DATA_W-1:0] left_d;
         logic signed [DATA_W-1:0] right_d;
         if (gi == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_mid_l
            assign left_d = cell_data[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_d = '0;
         end else begin : g_mid_r
            assign right_d = cell_data[gi+1];
         end
         ple_cell u_cell (
            .clock      (clock),
            .idx        (POS_W'(gi)),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[gi]),
            .sel_data   (cell_sel[gi])
         );
      end
   endgenerate

   // delete read-out: only the addressed cell drives its entry, all others drive zero
   always_comb begin
      sel_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_or = sel_or | cell_sel[i];
      end
   end

   // --- control --------------------------------------------------------------
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;
   assign pos_w     = {1'b0, req_data.position};
   assign cnt_w     = (POS_W+1)'(count_ff);
   assign last_step = ((POS_W+1)'(step_ff) + 1'b1) == cnt_w;
   assign head_hit  = (cell_data[0] == val_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.cmd      = CMD_HOLD;
      ctl.pos_idx  = req_data.position - 1'b1;
      ctl.value    = req_data.value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.status      = STS_OK;
               rsp_in.data_out    = '0;
               rsp_in.found_index = '0;
               rsp_in.last        = 1'b1;
               op_in              = req_data.operation;
               val_in             = req_data.value;
               step_in            = '0;
               found_in           = 1'b0;
               hit_idx_in         = '0;
               case (req_data.operation)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
                        rsp_in.status = STS_BAD_POS;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_in.status = STS_FULL;
                     end else begin
                        ctl.cmd  = CMD_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (pos_w == '0 || pos_w > cnt_w) begin
                        rsp_in.status = STS_BAD_POS;
                     end else begin
                        ctl.cmd         = CMD_DELETE;
                        count_in        = count_ff - 1'b1;
                        rsp_in.data_out = sel_or;
                     end
                  end
                  OP_LOCATE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STS_NOT_FOUND;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (slot_free) begin
               ctl.cmd     = CMD_ROTATE;
               ctl.pos_idx = POS_W'(count_ff - 1'b1);
               step_in     = step_ff + 1'b1;
               if (op_ff == OP_DUMP) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = STS_OK;
                  rsp_in.data_out    = cell_data[0];
                  rsp_in.found_index = '0;
                  rsp_in.last        = last_step;
               end else begin
                  if (head_hit && !found_ff) begin
                     found_in   = 1'b1;
                     hit_idx_in = POS_W'(step_ff) + 1'b1;
                  end
                  if (last_step) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.data_out    = '0;
                     rsp_in.last        = 1'b1;
                     if (found_in) begin
                        rsp_in.status      = STS_OK;
                        rsp_in.found_index = hit_idx_in;
                     end else begin
                        rsp_in.status      = STS_NOT_FOUND;
                        rsp_in.found_index = '0;
                     end
                  end
               end
               if (last_step) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff    <= step_in;
      found_ff   <= found_in;
      hit_idx_ff <= hit_idx_in;
      op_ff      <= op_in;
      val_ff     <= val_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // --- assertions -----------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list count above capacity");

   a_scan_count_held : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && $past(state_ff == S_SCAN) |-> $stable(count_ff))
      else $error("count changed during a scan");

   a_scan_step_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ((POS_W+1)'(step_ff) < cnt_w))
      else $error("scan step beyond list end");

   a_full_means_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == STS_FULL) |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status while list not full");

endmodule
